// ===== sv/lssm_pkg.sv =====
// ----------------------------------------------------------------------------
// lssm_pkg
// Types and codes shared by the lazy sorted set membership block.
// ----------------------------------------------------------------------------
package lssm_pkg;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [63:0] item_value;
	} lssm_req_t;

	typedef struct packed {
		logic        found;
		logic [63:0] member_value;
		logic        rejected;
	} lssm_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT_RD_KEY,
		ST_SORT_KEY,
		ST_SORT_RD_PREV,
		ST_SORT_CMP,
		ST_SRCH_RD,
		ST_SRCH_CMP
	} lssm_state_t;

endpackage

// ===== sv/lssm_ram.sv =====
// ----------------------------------------------------------------------------
// lssm_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lssm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/lazy_sorted_set_membership.sv =====
// ----------------------------------------------------------------------------
// lazy_sorted_set_membership
// Table of 64-bit values with append inserts and sort-on-demand queries.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req and raise start while busy is low; the item is taken at that
//   clock edge. Exactly one result per item appears on rsp for one cycle,
//   marked by done. The receiver cannot stall; it must take rsp when done.
//   Insert: the value is written at the end of the table and
//   done follows on the next cycle; busy stays low, so inserts can run
//   back to back. A full table drops the value and flags rejected.
//   Query: if inserts came since the last sort, the table is insertion
//   sorted in place first, then binary searched. The pace of both is set
//   by the single read port of the value memory with its registered
//   read data.
//   Reset clears the entry count and marks the empty table sorted; the
//   value memory needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module lazy_sorted_set_membership
	import lssm_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  lssm_req_t req,
	output logic      done,
	output lssm_rsp_t rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE = CW'(1);

	lssm_state_t    state_q, state_d;
	logic [CW-1:0]  count_q;
	logic           sorted_q;
	logic [CW-1:0]  i_q, j_q, lo_q, hi_q;
	logic [63:0]    key_q;       // element being placed during the sort
	logic [63:0]    target_q;    // value looked up by the query
	logic [CW-1:0]  mid;

	logic           we, re;
	logic [AW-1:0]  waddr, raddr;
	logic [63:0]    wdata, rdata;

	logic           accept;
	logic           rd_gt_key, rd_lt_tgt, rd_eq_tgt;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_gt_key = (rdata > key_q);
	assign rd_lt_tgt = (rdata < target_q);
	assign rd_eq_tgt = (rdata == target_q);

	lssm_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req.req_type == REQ_QUERY) begin
					state_d = sorted_q ? ST_SRCH_RD : ST_SORT_RD_KEY;
				end
			end
			ST_SORT_RD_KEY:  state_d = (i_q >= count_q) ? ST_SRCH_RD : ST_SORT_KEY;
			ST_SORT_KEY:     state_d = ST_SORT_RD_PREV;
			ST_SORT_RD_PREV: state_d = (j_q == '0) ? ST_SORT_RD_KEY : ST_SORT_CMP;
			ST_SORT_CMP:     state_d = rd_gt_key ? ST_SORT_RD_PREV : ST_SORT_RD_KEY;
			ST_SRCH_RD:      state_d = (lo_q < hi_q) ? ST_SRCH_CMP : ST_IDLE;
			ST_SRCH_CMP:     state_d = rd_eq_tgt ? ST_IDLE : ST_SRCH_RD;
			default:         state_d = ST_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = key_q;
		unique case (state_q)
			ST_IDLE: begin
				// append at the end of the table
				we    = accept && req.req_type == REQ_INSERT && count_q < CAP;
				waddr = count_q[AW-1:0];
				wdata = req.item_value;
			end
			ST_SORT_RD_KEY: begin
				re    = (i_q < count_q);
				raddr = i_q[AW-1:0];
			end
			ST_SORT_KEY: begin
			end
			ST_SORT_RD_PREV: begin
				if (j_q == '0) begin
					we    = 1'b1;
					waddr = '0;
				end else begin
					re    = 1'b1;
					raddr = j_q[AW-1:0] - AW'(1);
				end
			end
			ST_SORT_CMP: begin
				// shift the larger neighbor up, or drop the key in its slot
				we    = 1'b1;
				waddr = j_q[AW-1:0];
				wdata = rd_gt_key ? rdata : key_q;
			end
			ST_SRCH_RD: begin
				re    = (lo_q < hi_q);
				raddr = mid[AW-1:0];
			end
			ST_SRCH_CMP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			sorted_q <= 1'b1;
			done     <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						target_q <= req.item_value;
						i_q      <= ONE;
						lo_q     <= '0;
						hi_q     <= count_q;
						if (req.req_type == REQ_INSERT) begin
							done <= 1'b1;
							rsp  <= '{found: 1'b0, member_value: '0,
							          rejected: (count_q >= CAP)};
							if (count_q < CAP) begin
								count_q  <= count_q + ONE;
								sorted_q <= 1'b0;
							end
						end
					end
				end
				ST_SORT_RD_KEY: begin
					if (i_q >= count_q) begin
						sorted_q <= 1'b1;
					end
				end
				ST_SORT_KEY: begin
					key_q <= rdata;
					j_q   <= i_q;
				end
				ST_SORT_RD_PREV: begin
					if (j_q == '0) begin
						i_q <= i_q + ONE;
					end
				end
				ST_SORT_CMP: begin
					if (rd_gt_key) begin
						j_q <= j_q - ONE;
					end else begin
						i_q <= i_q + ONE;
					end
				end
				ST_SRCH_RD: begin
					if (!(lo_q < hi_q)) begin
						done <= 1'b1;
						rsp  <= '{found: 1'b0, member_value: '0, rejected: 1'b0};
					end
				end
				ST_SRCH_CMP: begin
					if (rd_eq_tgt) begin
						done <= 1'b1;
						rsp  <= '{found: 1'b1, member_value: target_q, rejected: 1'b0};
					end else if (rd_lt_tgt) begin
						lo_q <= mid + ONE;
					end else begin
						hi_q <= mid;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
